// ----- rtl/slid_pkg.sv -----
// Package for the sorted list block: sizes, operation and status codes,
// and the structs passed between the top level and the cell row.
// No dependencies.
`default_nettype none

package slid_pkg;

   localparam int Capacity   = 16;
   localparam int ValueWidth = 32;
   localparam int CountWidth = $clog2(Capacity + 1);
   localparam int RspCountWidth = 5;

   typedef enum logic [0:0] {
      OP_INSERT = 1'b0,
      OP_DELETE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_EMPTY     = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   // Broadcast from the top level to every cell.
   typedef struct packed {
      logic                          ins_en;
      logic                          del_en;
      logic signed [ValueWidth-1:0]  key;
   } cmd_type;

   // What a cell shows its neighbours and the top level.
   typedef struct packed {
      logic                          occ;
      logic                          lt;   // occupied and entry below key
      logic                          eq;   // occupied and entry equal to key
      logic signed [ValueWidth-1:0]  entry;
   } link_type;

endpackage

`default_nettype wire

// ----- rtl/sorted_list_insert_delete.sv -----
// Sorted list of signed 32-bit values: insert in order or delete one match.
// Top level; depends on slid_pkg and slid_cell.
`default_nettype none

// A row of cells keeps up to slid_pkg::Capacity signed values in ascending
// order, one value per cell. Every cell compares the request value with its
// own element in the same cycle and, on a change, takes its neighbour's
// element, so the whole row updates together: a request is taken on any
// edge with start high and busy low, and its result (status and element
// count after the operation) appears on rsp_* with rsp_valid high for exactly
// the next cycle. busy is high only during reset, so one transfer per cycle
// is sustained. The receiver cannot stall; results must be taken as shown.
// Insert places the value ahead of equal ones and is refused when the list
// is full; delete removes one equal element, or reports an empty list or a
// value that is not present. Contents are unchanged on any refused request.

module sorted_list_insert_delete (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic                               req_operation,
   input  wire logic signed [slid_pkg::ValueWidth-1:0] req_value,
   output logic                                    rsp_valid,
   output logic [1:0]                              rsp_status,
   output logic [slid_pkg::RspCountWidth-1:0]      rsp_count
);

   localparam int Cap = slid_pkg::Capacity;
   localparam int CW  = slid_pkg::CountWidth;

   logic                    accept;
   logic                    full, empty, found;
   slid_pkg::cmd_type       cmd;
   slid_pkg::link_type      links [Cap];
   slid_pkg::link_type      head_link, tail_link;
   logic [Cap-1:0]          occ_vec, eq_vec;
   slid_pkg::status_type    status;

   logic [CW-1:0]           count_ff, count_in;
   logic                    rsp_valid_ff;
   slid_pkg::status_type    rsp_status_ff;
   logic [CW-1:0]           rsp_count_ff;

   assign busy   = reset;
   assign accept = start && !busy;

   // edge tie-offs: the head looks like a smaller occupied element, the tail
   // like an empty cell
   assign head_link = '{occ: 1'b1, lt: 1'b1, eq: 1'b0, entry: '0};
   assign tail_link = '{occ: 1'b0, lt: 1'b0, eq: 1'b0, entry: '0};

   for (genvar i = 0; i < Cap; i++) begin : g_cell
      assign occ_vec[i] = links[i].occ;
      assign eq_vec[i]  = links[i].eq;
      slid_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .prev_link ((i == 0)       ? head_link : links[(i == 0) ? 0 : i - 1]),
         .next_link ((i == Cap - 1) ? tail_link : links[(i == Cap - 1) ? i : i + 1]),
         .link      (links[i])
      );
   end

   // occupancy is a thermometer code, so the end cells tell full and empty
   assign full  = occ_vec[Cap-1];
   assign empty = !occ_vec[0];
   assign found = |eq_vec;

   always_comb begin
      cmd.key    = req_value;
      cmd.ins_en = 1'b0;
      cmd.del_en = 1'b0;
      count_in   = count_ff;
      status     = slid_pkg::STATUS_OK;
      if (req_operation == slid_pkg::OP_INSERT) begin
         if (full) begin
            status = slid_pkg::STATUS_FULL;
         end else begin
            cmd.ins_en = accept;
            if (accept) count_in = count_ff + CW'(1);
         end
      end else begin
         if (empty) begin
            status = slid_pkg::STATUS_EMPTY;
         end else if (!found) begin
            status = slid_pkg::STATUS_NOT_FOUND;
         end else begin
            cmd.del_en = accept;
            if (accept) count_in = count_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
   end

   // result payload, loaded on each transfer
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= status;
         rsp_count_ff  <= count_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_count  = slid_pkg::RspCountWidth'(rsp_count_ff);

   // element count tracks the occupied cells
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) == $countones(occ_vec))
      else $error("count register disagrees with occupied cells");

   // occupied cells form a solid run from the head
   a_thermometer: assert property (@(posedge clock) disable iff (reset)
      ((occ_vec & (occ_vec + Cap'(1))) == '0))
      else $error("occupied cells not contiguous");

   // a result follows each transfer in the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("missing result after request");

   // refused requests leave the count alone
   a_refused_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != slid_pkg::STATUS_OK) |-> $stable(count_ff))
      else $error("count changed on refused request");

endmodule

`default_nettype wire

// ----- rtl/slid_cell.sv -----
// One cell of the sorted list: holds a single element and its occupied flag.
// Depends on slid_pkg.
`default_nettype none

module slid_cell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire slid_pkg::cmd_type  cmd,
   input  wire slid_pkg::link_type prev_link,
   input  wire slid_pkg::link_type next_link,
   output slid_pkg::link_type      link
);

   logic                                  occ_ff, occ_in;
   logic signed [slid_pkg::ValueWidth-1:0] entry_ff, entry_in;
   logic                                  lt, eq;

   assign lt = occ_ff && (entry_ff < cmd.key);
   assign eq = occ_ff && (entry_ff == cmd.key);

   always_comb begin
      occ_in   = occ_ff;
      entry_in = entry_ff;
      if (cmd.ins_en) begin
         // cells at or after the slot move up one place
         occ_in = occ_ff | prev_link.occ;
         if (!lt) begin
            entry_in = prev_link.lt ? cmd.key : prev_link.entry;
         end
      end else if (cmd.del_en) begin
         // cells at or after the first match pull from the right
         if (!lt) begin
            occ_in   = next_link.occ;
            entry_in = next_link.entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign link.occ   = occ_ff;
   assign link.lt    = lt;
   assign link.eq    = eq;
   assign link.entry = entry_ff;

endmodule

`default_nettype wire

// ----- tb/slid_checker.sv -----
// Checker for the sorted list block: watches the request and response
// channels, keeps its own ordered copy of the list and compares every response.
// Depends on slid_pkg.

module slid_checker
   import slid_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic                         busy,
   input  wire logic                         req_operation,
   input  wire logic signed [ValueWidth-1:0] req_value,
   input  wire logic                         rsp_valid,
   input  wire logic [1:0]                   rsp_status,
   input  wire logic [RspCountWidth-1:0]     rsp_count,
   output int                                fail_count,
   output int                                pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      status_type                 status;
      logic [RspCountWidth-1:0]   count;
   } outcome_type;

   // Shadow list, ascending, valid below held_count.
   logic signed [ValueWidth-1:0] held_values [Capacity];
   int                           held_count;
   outcome_type                  awaited_outcomes [$];
   int                           reported;

   initial begin
      fail_count = 0;
      pending    = 0;
      held_count = 0;
      reported   = 0;
   end

   // Applies one request to the shadow list and returns the response it earns.
   function automatic outcome_type apply_request(op_type op,
                                                 logic signed [ValueWidth-1:0] v);
      outcome_type r;
      int          pos;
      r.status = STATUS_OK;
      pos = 0;
      if (op == OP_INSERT) begin
         if (held_count >= Capacity) begin
            r.status = STATUS_FULL;
         end else begin
            // new value goes ahead of any equal ones
            while (pos < held_count && held_values[pos] < v) pos++;
            for (int i = held_count; i > pos; i--) held_values[i] = held_values[i-1];
            held_values[pos] = v;
            held_count++;
         end
      end else if (held_count == 0) begin
         r.status = STATUS_EMPTY;
      end else begin
         while (pos < held_count && held_values[pos] != v) pos++;
         if (pos == held_count) begin
            r.status = STATUS_NOT_FOUND;
         end else begin
            for (int i = pos; i < held_count - 1; i++) held_values[i] = held_values[i+1];
            held_count--;
         end
      end
      r.count = RspCountWidth'(held_count);
      return r;
   endfunction

   always @(posedge clock) begin : watch
      outcome_type want;
      int          fails;
      fails = 0;
      if (reset) begin
         held_count = 0;
         awaited_outcomes.delete();
      end else begin
         // response first: it belongs to a request taken at an earlier edge
         if (rsp_valid) begin
            if (awaited_outcomes.size() == 0) begin
               fails++;
               if (reported < 10)
                  $display("%0t: response with none awaited: status %0d count %0d",
                           $realtime, rsp_status, rsp_count);
               reported++;
            end else begin
               want = awaited_outcomes.pop_front();
               if (rsp_status !== want.status || rsp_count !== want.count) begin
                  fails++;
                  if (reported < 10)
                     $display("%0t: expected status %0d count %0d, got status %0d count %0d",
                              $realtime, want.status, want.count, rsp_status, rsp_count);
                  reported++;
               end
            end
         end
         if (start && !busy)
            awaited_outcomes.push_back(apply_request(op_type'(req_operation), req_value));
      end
      fail_count <= fail_count + fails;
      pending    <= awaited_outcomes.size();
   end

endmodule

// ----- tb/testbench.sv -----
// Top of the sorted list testbench: clock, reset, request stimulus, watchdog
// and verdict. Depends on slid_pkg, slid_checker and sorted_list_insert_delete.

module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import slid_pkg::*;

   localparam int RandomItems = 1800;
   localparam int QuietLimit  = 1000;   // cycles with no transfer before giving up

   logic                         clock;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic                         req_operation;
   logic signed [ValueWidth-1:0] req_value;
   logic                         rsp_valid;
   logic [1:0]                   rsp_status;
   logic [RspCountWidth-1:0]     rsp_count;
   int                           fail_count;
   int                           pending;
   int                           quiet_cycles;

   // Values recently offered for insertion; deletes mostly pick from here so
   // that they hit stored elements, duplicates included.
   logic signed [ValueWidth-1:0] recent_keys [$];

   sorted_list_insert_delete DUT (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_operation (req_operation),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_count     (rsp_count)
   );

   slid_checker list_check (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_operation (req_operation),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_count     (rsp_count),
      .fail_count    (fail_count),
      .pending       (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog: any request or response transfer counts as progress. Reset
   // counts too, so the reset stretch never trips it.
   initial quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("testbench NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // One request transfer. Fields change on the falling edge; the transfer
   // happens on the first rising edge that sees busy low. busy is read just
   // after the edge, before the block's own updates land, so it is the value
   // the block itself saw. start is left high: the next call or an idle
   // stretch decides what it does next.
   task automatic transfer_item(op_type op, logic signed [ValueWidth-1:0] v);
      @(negedge clock);
      start         <= 1'b1;
      req_operation <= op;
      req_value     <= v;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (op == OP_INSERT) begin
         recent_keys.push_back(v);
         if (recent_keys.size() > 24) void'(recent_keys.pop_front());
      end
   endtask

   // Idle stretch: start low, fields scrambled as noise the block must ignore.
   task automatic hold_off(int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start         <= 1'b0;
         req_operation <= 1'($urandom_range(0, 1));
         req_value     <= $urandom;
      end
   endtask

   // Value mix: a narrow band around zero for plenty of duplicates and hits,
   // the two's complement extremes, and full-width random words.
   function automatic logic signed [ValueWidth-1:0] pick_value();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 40)
         return $urandom_range(0, 15) - 8;
      if (roll < 55) begin
         case ($urandom_range(0, 3))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return 32'sh7fff_fffe;
            default: return 32'sh8000_0001;
         endcase
      end
      return $urandom;
   endfunction

   initial begin : stimulus
      int                           insert_pct;
      int                           burst;
      int                           idx;
      int                           sent;
      op_type                       op;
      logic signed [ValueWidth-1:0] v;

      reset         = 1'b1;
      start         = 1'b0;
      req_operation = 1'b0;
      req_value     = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      transfer_item(OP_DELETE, 32'sd0);              // delete on an empty list
      transfer_item(OP_INSERT, 32'sd3);
      transfer_item(OP_DELETE, 32'sd4);              // sole element, different value
      transfer_item(OP_DELETE, 32'sd3);              // back to empty
      transfer_item(OP_INSERT, 32'sh7fff_ffff);
      transfer_item(OP_INSERT, 32'sh7fff_ffff);      // equal to the last element
      transfer_item(OP_INSERT, 32'sh8000_0000);
      transfer_item(OP_INSERT, 32'sd0);
      transfer_item(OP_INSERT, -32'sd1);
      transfer_item(OP_INSERT, 32'sd5);
      transfer_item(OP_INSERT, 32'sd5);              // duplicate in the middle
      transfer_item(OP_DELETE, 32'sd5);
      transfer_item(OP_DELETE, 32'sd6);              // absent, inside the range
      transfer_item(OP_DELETE, 32'sh7fff_ffff);
      transfer_item(OP_DELETE, 32'sh8000_0000);
      // four held now; fill the remaining twelve slots, then push past full
      for (int i = 0; i < Capacity - 4; i++)
         transfer_item(OP_INSERT, $urandom_range(0, 1000) - 500);
      transfer_item(OP_INSERT, 32'sd1);              // refused: list full
      transfer_item(OP_DELETE, 32'sh1234_5678);      // absent with the list full

      // ---- random part ----
      // Bursts lean towards filling or draining so the list keeps swinging
      // between empty and full; gaps between bursts are sometimes absent.
      sent = 0;
      while (sent < RandomItems) begin
         case ($urandom_range(0, 2))
            0:       insert_pct = 85;
            1:       insert_pct = 50;
            default: insert_pct = 15;
         endcase
         burst = $urandom_range(1, 40);
         for (int b = 0; b < burst; b++) begin
            if ($urandom_range(0, 99) < insert_pct) begin
               op = OP_INSERT;
               v  = pick_value();
            end else begin
               op = OP_DELETE;
               if (recent_keys.size() != 0 && $urandom_range(0, 99) < 65) begin
                  idx = $urandom_range(0, recent_keys.size() - 1);
                  v   = recent_keys[idx];
                  recent_keys.delete(idx);
               end else begin
                  v = pick_value();
               end
            end
            transfer_item(op, v);
            sent++;
         end
         if ($urandom_range(0, 9) >= 3) hold_off($urandom_range(1, 8));
      end

      // ---- drain and verdict ----
      hold_off(1);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (fail_count == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule
